[hw/rtl/mbrf_pkg.sv]
package mbrf_pkg;

  localparam int REG_WIDTH_DEF = 32;
  localparam int EXT_W         = 64;

  localparam int OP_W     = 3;
  localparam int IDX_W    = 4;
  localparam int MODE_W   = 5;
  localparam int DATA_W   = 32;
  localparam int NUM_REGS = 32;
  localparam int NUM_PSRS = 6;
  localparam int SLOT_W   = $clog2(NUM_REGS);
  localparam int PSLOT_W  = $clog2(NUM_PSRS);

  localparam logic [OP_W-1:0] OP_RD_REG  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_REG  = 3'd1;
  localparam logic [OP_W-1:0] OP_RD_PSR  = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_PSR  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_MODE = 3'd4;

  localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
  localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
  localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
  localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
  localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
  localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
  localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

  localparam logic [SLOT_W-1:0]  SLOT_FIQ_R8  = 5'd16;
  localparam logic [SLOT_W-1:0]  SLOT_FIQ_R13 = 5'd21;
  localparam logic [SLOT_W-1:0]  SLOT_IRQ_R13 = 5'd23;
  localparam logic [SLOT_W-1:0]  SLOT_SVC_R13 = 5'd25;
  localparam logic [SLOT_W-1:0]  SLOT_ABT_R13 = 5'd27;
  localparam logic [SLOT_W-1:0]  SLOT_UND_R13 = 5'd29;
  localparam logic [SLOT_W-1:0]  SCRATCH_REG  = 5'd31;

  localparam logic [PSLOT_W-1:0] PSLOT_FIQ   = 3'd0;
  localparam logic [PSLOT_W-1:0] PSLOT_IRQ   = 3'd1;
  localparam logic [PSLOT_W-1:0] PSLOT_SVC   = 3'd2;
  localparam logic [PSLOT_W-1:0] PSLOT_ABT   = 3'd3;
  localparam logic [PSLOT_W-1:0] PSLOT_UND   = 3'd4;
  localparam logic [PSLOT_W-1:0] SCRATCH_PSR = 3'd5;

  // physical slot of a logical register in the given mode
  function automatic logic [SLOT_W-1:0] reg_slot(input logic [MODE_W-1:0] mode,
                                                 input logic [IDX_W-1:0]  idx);
    logic [SLOT_W-1:0] base;
    logic [SLOT_W-1:0] plain;
    plain = SLOT_W'(idx);
    base  = SCRATCH_REG;
    if (idx < 4'd8 || idx == 4'd15) begin
      reg_slot = plain;
    end else if (idx <= 4'd12) begin
      reg_slot = (mode == MODE_FIQ) ? SLOT_FIQ_R8 + plain - SLOT_W'(8) : plain;
    end else begin
      case (mode)
        MODE_USR, MODE_SYS: base = SLOT_W'(13);
        MODE_FIQ: base = SLOT_FIQ_R13;
        MODE_IRQ: base = SLOT_IRQ_R13;
        MODE_SVC: base = SLOT_SVC_R13;
        MODE_ABT: base = SLOT_ABT_R13;
        MODE_UND: base = SLOT_UND_R13;
        default:  base = SCRATCH_REG;
      endcase
      // undefined modes collapse r13 and r14 onto the one scratch slot
      if (base == SCRATCH_REG) begin
        reg_slot = SCRATCH_REG;
      end else begin
        reg_slot = (idx == 4'd13) ? base : base + SLOT_W'(1);
      end
    end
  endfunction

  function automatic logic [PSLOT_W-1:0] psr_slot(input logic [MODE_W-1:0] mode);
    case (mode)
      MODE_FIQ: psr_slot = PSLOT_FIQ;
      MODE_IRQ: psr_slot = PSLOT_IRQ;
      MODE_SVC: psr_slot = PSLOT_SVC;
      MODE_ABT: psr_slot = PSLOT_ABT;
      MODE_UND: psr_slot = PSLOT_UND;
      default:  psr_slot = SCRATCH_PSR;
    endcase
  endfunction

endpackage

[hw/rtl/mode_banked_register_file.sv]
// Mode-banked register file: one access per clock. A transaction is taken when start
// is high and busy is low; its result appears with done exactly one cycle later,
// set by the one-cycle read latency of the register and saved-status memories, and
// the next transaction may be taken in that same cycle. busy is high only during
// reset and the cycle after it. The receiver cannot stall: done lasts one cycle.
module mode_banked_register_file #(
  parameter int REG_WIDTH = mbrf_pkg::REG_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mbrf_pkg::OP_W-1:0]     opcode,
  input  logic [mbrf_pkg::IDX_W-1:0]    reg_index,
  input  logic [mbrf_pkg::DATA_W-1:0]   write_value,
  input  logic [mbrf_pkg::MODE_W-1:0]   new_mode,
  output logic                          done,
  output logic [mbrf_pkg::DATA_W-1:0]   read_value,
  output logic                          is_privileged,
  output logic                          is_exception_mode,
  output logic                          hit_scratch
);
  import mbrf_pkg::*;

  logic [REG_WIDTH-1:0] reg_mem [NUM_REGS];
  logic [DATA_W-1:0]    psr_mem [NUM_PSRS];

  logic [MODE_W-1:0]    mode;
  logic [MODE_W-1:0]    mode_next;
  logic [NUM_REGS-1:0]  reg_vld;
  logic [NUM_PSRS-1:0]  psr_vld;

  logic                 accept;
  logic [SLOT_W-1:0]    rslot;
  logic [PSLOT_W-1:0]   pslot;
  logic                 hit;
  logic [EXT_W-1:0]     wv_ext;
  logic [REG_WIDTH-1:0] wr_data;
  logic [EXT_W-1:0]     reg_ext;

  logic [REG_WIDTH-1:0] reg_rdata;
  logic [DATA_W-1:0]    psr_rdata;
  logic                 sel_reg;
  logic                 sel_psr;
  logic                 rd_vld;

  assign accept  = start && !busy;
  assign rslot   = reg_slot(mode, reg_index);
  assign pslot   = psr_slot(mode);
  assign wv_ext  = EXT_W'(write_value);
  assign wr_data = wv_ext[REG_WIDTH-1:0];
  assign reg_ext = EXT_W'(reg_rdata);

  always_comb begin
    mode_next = mode;
    if (accept && opcode == OP_SET_MODE) begin
      mode_next = new_mode;
    end
  end

  always_comb begin
    case (opcode)
      OP_RD_REG, OP_WR_REG: hit = (rslot == SCRATCH_REG);
      OP_RD_PSR, OP_WR_PSR: hit = (pslot == SCRATCH_PSR);
      default:              hit = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_SVC;
      reg_vld <= '0;
      psr_vld <= '0;
      done    <= 1'b0;
      busy    <= 1'b1;
    end else begin
      busy <= 1'b0;
      done <= accept;
      mode <= mode_next;
      if (accept && opcode == OP_WR_REG) begin
        reg_vld[rslot] <= 1'b1;
      end
      if (accept && opcode == OP_WR_PSR) begin
        psr_vld[pslot] <= 1'b1;
      end
    end
  end

  // memories: read old data and write in the accept cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      reg_rdata <= reg_mem[rslot];
      psr_rdata <= psr_mem[pslot];
      if (opcode == OP_WR_REG) begin
        reg_mem[rslot] <= wr_data;
      end
      if (opcode == OP_WR_PSR) begin
        psr_mem[pslot] <= write_value;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_reg           <= (opcode == OP_RD_REG);
      sel_psr           <= (opcode == OP_RD_PSR);
      rd_vld            <= (opcode == OP_RD_REG) ? reg_vld[rslot] : psr_vld[pslot];
      hit_scratch       <= hit;
      is_privileged     <= (mode_next != MODE_USR);
      is_exception_mode <= (mode_next != MODE_USR) && (mode_next != MODE_SYS);
    end
  end

  // never-written entries read as zero
  always_comb begin
    read_value = '0;
    if (rd_vld && sel_reg) begin
      read_value = reg_ext[DATA_W-1:0];
    end else if (rd_vld && sel_psr) begin
      read_value = psr_rdata;
    end
  end

endmodule
